// ----- hw/rtl/sas_pkg.sv -----
// package for the sparse array store: sizes, codes, state type and memory request bundle
// used by the channel interfaces, the storage module and the top level
// no dependencies

package sas_pkg;

    localparam int CAPACITY    = 1024;
    localparam int VALUE_WIDTH = 64;

    localparam int CAP_BITS = $clog2(CAPACITY);
    localparam int LEN_W    = CAP_BITS + 1;
    localparam int PW_BITS  = (CAP_BITS > 5) ? 5 : CAP_BITS - 1;
    localparam int PW       = 1 << PW_BITS;
    localparam int ROW_AW   = CAP_BITS - PW_BITS;
    localparam int ROWS     = 1 << ROW_AW;

    localparam logic [ROW_AW-1:0] ROW_LAST = ROW_AW'(ROWS - 1);

    typedef enum logic [1:0] {
        FUNC_GET    = 2'd0,
        FUNC_SET    = 2'd1,
        FUNC_DEL    = 2'd2,
        FUNC_SETLEN = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_DONE     = 2'd0,
        ST_ABSENT   = 2'd1,
        ST_CAPACITY = 2'd2
    } t_status;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SWEEP,
        S_READ,
        S_EXEC,
        S_CLEAR
    } t_state;

    typedef struct packed {
        logic                   rd_en;
        logic [CAP_BITS-1:0]    val_raddr;
        logic [ROW_AW-1:0]      pres_raddr;
        logic                   val_we;
        logic [CAP_BITS-1:0]    val_waddr;
        logic [VALUE_WIDTH-1:0] val_wdata;
        logic                   pres_we;
        logic [ROW_AW-1:0]      pres_waddr;
        logic [PW-1:0]          pres_wdata;
    } t_mem_req;

    // ones in the bits below n
    function automatic logic [PW-1:0] low_mask(input logic [PW_BITS-1:0] n);
        logic [PW-1:0] m;
        m = (PW'(1) << n) - PW'(1);
        return m;
    endfunction

    // presence row with every slot below len marked
    function automatic logic [PW-1:0] row_fill(input logic [ROW_AW-1:0] row,
                                               input logic [LEN_W-1:0]  len);
        logic [LEN_W-PW_BITS-1:0] full;
        logic [LEN_W-PW_BITS-1:0] r;
        logic [PW-1:0]            m;
        full = len[LEN_W-1:PW_BITS];
        r    = {1'b0, row};
        if (r < full) begin
            m = '1;
        end else if (r == full) begin
            m = low_mask(len[PW_BITS-1:0]);
        end else begin
            m = '0;
        end
        return m;
    endfunction

endpackage

// ----- hw/rtl/sas_if.sv -----
// command and response channel interfaces for the sparse array store
// depends on sas_pkg for the length width

interface sas_cmd_if;
    logic        valid;
    logic        ready;
    logic [1:0]  func;
    logic [31:0] index;
    logic [63:0] write_value;
    logic [31:0] new_length;

    modport source (output valid, output func, output index, output write_value,
                    output new_length, input ready);
    modport sink   (input valid, input func, input index, input write_value,
                    input new_length, output ready);
endinterface

interface sas_rsp_if;
    logic                    valid;
    logic                    ready;
    logic [1:0]              status;
    logic [63:0]             read_value;
    logic [sas_pkg::LEN_W-1:0] cur_length;

    modport source (output valid, output status, output read_value, output cur_length,
                    input ready);
    modport sink   (input valid, input status, input read_value, input cur_length,
                    output ready);
endinterface

// ----- hw/rtl/sas_store.sv -----
// value memory and presence row memory of the sparse array store
// one read and one write port each, registered read data; depends on sas_pkg

module sas_store (
    input  logic                            i_clk,
    input  sas_pkg::t_mem_req               i_req,
    output logic [sas_pkg::VALUE_WIDTH-1:0] o_val_rdata,
    output logic [sas_pkg::PW-1:0]          o_pres_rdata
);

    logic [sas_pkg::VALUE_WIDTH-1:0] r_val_mem  [sas_pkg::CAPACITY];
    logic [sas_pkg::PW-1:0]          r_pres_mem [sas_pkg::ROWS];
    logic [sas_pkg::VALUE_WIDTH-1:0] r_val_rdata;
    logic [sas_pkg::PW-1:0]          r_pres_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.val_we) begin
            r_val_mem[i_req.val_waddr] <= i_req.val_wdata;
        end
        if (i_req.rd_en) begin
            r_val_rdata <= r_val_mem[i_req.val_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.pres_we) begin
            r_pres_mem[i_req.pres_waddr] <= i_req.pres_wdata;
        end
        if (i_req.rd_en) begin
            r_pres_rdata <= r_pres_mem[i_req.pres_raddr];
        end
    end

    assign o_val_rdata  = r_val_rdata;
    assign o_pres_rdata = r_pres_rdata;

endmodule

// ----- hw/rtl/sparse_array_store_with_holes.sv -----
// sparse array store with presence bits: top level, control and result register
// result: registered after the execute step, which waits while a response is held; when the store
//   first turns sparse, the presence memory is rewritten one row per cycle, then re-read
// a new command is taken only in idle, after the read-then-write pass over the memories;
//   a sparse truncation also holds the next transfer while each further presence row is cleared
// reset: length zero, dense mode, memories not cleared; depends on sas_pkg, sas_if, sas_store

module sparse_array_store_with_holes (
    input  logic     i_clk,
    input  logic     i_rst_n,
    sas_cmd_if.sink  i_cmd,
    sas_rsp_if.source o_rsp
);

    sas_pkg::t_state r_state, n_state;

    sas_pkg::t_func                  r_func, n_func;
    logic                            r_idx_ok, n_idx_ok;
    logic [sas_pkg::CAP_BITS-1:0]    r_idx_lo, n_idx_lo;
    logic [sas_pkg::VALUE_WIDTH-1:0] r_wval, n_wval;
    logic                            r_nl_ok, n_nl_ok;
    logic [sas_pkg::LEN_W-1:0]       r_nl, n_nl;

    logic [sas_pkg::LEN_W-1:0]       r_len, n_len;
    logic                            r_dense, n_dense;
    logic [sas_pkg::ROW_AW-1:0]      r_row, n_row;
    logic [sas_pkg::ROW_AW-1:0]      r_row_end, n_row_end;

    logic                            r_out_valid, n_out_valid;
    sas_pkg::t_status                r_status, n_status;
    logic [63:0]                     r_rdata, n_rdata;
    logic [sas_pkg::LEN_W-1:0]       r_out_len, n_out_len;

    sas_pkg::t_mem_req               mem_req;
    logic [sas_pkg::VALUE_WIDTH-1:0] w_val_rdata;
    logic [sas_pkg::PW-1:0]          w_pres_rdata;

    sas_pkg::t_func                  in_func;
    logic                            in_idx_ok;
    logic                            in_nl_ok;
    logic [sas_pkg::LEN_W-1:0]       in_idx_l;
    logic [sas_pkg::LEN_W-1:0]       in_nl_l;
    logic                            in_sparse;
    logic                            accept;

    logic [sas_pkg::LEN_W-1:0]       ex_idx_l;
    logic [sas_pkg::PW-1:0]          ex_bit;
    logic                            pres_bit;
    logic                            out_free;
    logic                            ex_trunc;
    logic                            ex_clear;
    logic [sas_pkg::LEN_W-1:0]       len_m1;
    logic [sas_pkg::ROW_AW-1:0]      trunc_row;
    logic [sas_pkg::ROW_AW-1:0]      last_row;

    sas_store u_store (
        .i_clk        (i_clk),
        .i_req        (mem_req),
        .o_val_rdata  (w_val_rdata),
        .o_pres_rdata (w_pres_rdata)
    );

    // command decode
    assign in_func   = sas_pkg::t_func'(i_cmd.func);
    assign in_idx_ok = i_cmd.index < 32'(sas_pkg::CAPACITY);
    assign in_nl_ok  = i_cmd.new_length <= 32'(sas_pkg::CAPACITY);
    assign in_idx_l  = {1'b0, i_cmd.index[sas_pkg::CAP_BITS-1:0]};
    assign in_nl_l   = i_cmd.new_length[sas_pkg::LEN_W-1:0];
    assign in_sparse = r_dense &&
                       ((in_func == sas_pkg::FUNC_SET && in_idx_ok && in_idx_l > r_len) ||
                        (in_func == sas_pkg::FUNC_DEL && in_idx_ok) ||
                        (in_func == sas_pkg::FUNC_SETLEN && in_nl_ok && in_nl_l > r_len));
    assign accept    = (r_state == sas_pkg::S_IDLE) && i_cmd.valid;
    assign i_cmd.ready = (r_state == sas_pkg::S_IDLE);

    // execute-step terms
    assign ex_idx_l  = {1'b0, r_idx_lo};
    assign ex_bit    = sas_pkg::PW'(1) << r_idx_lo[sas_pkg::PW_BITS-1:0];
    assign pres_bit  = w_pres_rdata[r_idx_lo[sas_pkg::PW_BITS-1:0]];
    assign out_free  = !r_out_valid || o_rsp.ready;
    assign len_m1    = r_len - sas_pkg::LEN_W'(1);
    assign trunc_row = r_nl[sas_pkg::CAP_BITS-1:sas_pkg::PW_BITS];
    assign last_row  = len_m1[sas_pkg::CAP_BITS-1:sas_pkg::PW_BITS];
    assign ex_trunc  = (r_func == sas_pkg::FUNC_SETLEN) && r_nl_ok && !r_dense &&
                       (r_nl < r_len);
    assign ex_clear  = ex_trunc && (last_row != trunc_row);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            sas_pkg::S_IDLE: begin
                if (accept) begin
                    n_state = in_sparse ? sas_pkg::S_SWEEP : sas_pkg::S_EXEC;
                end
            end
            sas_pkg::S_SWEEP: begin
                if (r_row == sas_pkg::ROW_LAST) begin
                    n_state = sas_pkg::S_READ;
                end
            end
            sas_pkg::S_READ: begin
                n_state = sas_pkg::S_EXEC;
            end
            sas_pkg::S_EXEC: begin
                if (out_free) begin
                    n_state = ex_clear ? sas_pkg::S_CLEAR : sas_pkg::S_IDLE;
                end
            end
            sas_pkg::S_CLEAR: begin
                if (r_row == r_row_end) begin
                    n_state = sas_pkg::S_IDLE;
                end
            end
            default: n_state = sas_pkg::S_IDLE;
        endcase
    end

    // datapath and memory control
    always_comb begin
        n_func      = r_func;
        n_idx_ok    = r_idx_ok;
        n_idx_lo    = r_idx_lo;
        n_wval      = r_wval;
        n_nl_ok     = r_nl_ok;
        n_nl        = r_nl;
        n_len       = r_len;
        n_dense     = r_dense;
        n_row       = r_row;
        n_row_end   = r_row_end;
        n_out_valid = r_out_valid && !o_rsp.ready;
        n_status    = r_status;
        n_rdata     = r_rdata;
        n_out_len   = r_out_len;
        mem_req     = '0;

        unique case (r_state)
            sas_pkg::S_IDLE: begin
                mem_req.rd_en      = i_cmd.valid;
                mem_req.val_raddr  = i_cmd.index[sas_pkg::CAP_BITS-1:0];
                mem_req.pres_raddr = (in_func == sas_pkg::FUNC_SETLEN) ?
                    i_cmd.new_length[sas_pkg::CAP_BITS-1:sas_pkg::PW_BITS] :
                    i_cmd.index[sas_pkg::CAP_BITS-1:sas_pkg::PW_BITS];
                if (accept) begin
                    n_func   = in_func;
                    n_idx_ok = in_idx_ok;
                    n_idx_lo = i_cmd.index[sas_pkg::CAP_BITS-1:0];
                    n_wval   = i_cmd.write_value[sas_pkg::VALUE_WIDTH-1:0];
                    n_nl_ok  = in_nl_ok;
                    n_nl     = in_nl_l;
                    n_row    = '0;
                end
            end
            sas_pkg::S_SWEEP: begin
                mem_req.pres_we    = 1'b1;
                mem_req.pres_waddr = r_row;
                mem_req.pres_wdata = sas_pkg::row_fill(r_row, r_len);
                n_row = r_row + sas_pkg::ROW_AW'(1);
                if (r_row == sas_pkg::ROW_LAST) begin
                    n_dense = 1'b0;
                end
            end
            sas_pkg::S_READ: begin
                mem_req.rd_en      = 1'b1;
                mem_req.val_raddr  = r_idx_lo;
                mem_req.pres_raddr = (r_func == sas_pkg::FUNC_SETLEN) ? trunc_row :
                    r_idx_lo[sas_pkg::CAP_BITS-1:sas_pkg::PW_BITS];
            end
            sas_pkg::S_EXEC: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_rdata     = '0;
                    n_status    = sas_pkg::ST_DONE;
                    unique case (r_func)
                        sas_pkg::FUNC_GET: begin
                            if (r_idx_ok && ex_idx_l < r_len && (r_dense || pres_bit)) begin
                                n_rdata = 64'(w_val_rdata);
                            end else begin
                                n_status = sas_pkg::ST_ABSENT;
                            end
                        end
                        sas_pkg::FUNC_SET: begin
                            if (!r_idx_ok) begin
                                n_status = sas_pkg::ST_CAPACITY;
                            end else begin
                                mem_req.val_we    = 1'b1;
                                mem_req.val_waddr = r_idx_lo;
                                mem_req.val_wdata = r_wval;
                                if (!r_dense) begin
                                    mem_req.pres_we    = 1'b1;
                                    mem_req.pres_waddr =
                                        r_idx_lo[sas_pkg::CAP_BITS-1:sas_pkg::PW_BITS];
                                    mem_req.pres_wdata = w_pres_rdata | ex_bit;
                                end
                                if (ex_idx_l >= r_len) begin
                                    n_len = ex_idx_l + sas_pkg::LEN_W'(1);
                                end
                            end
                        end
                        sas_pkg::FUNC_DEL: begin
                            if (!r_idx_ok || !pres_bit) begin
                                n_status = sas_pkg::ST_ABSENT;
                            end else begin
                                mem_req.pres_we    = 1'b1;
                                mem_req.pres_waddr =
                                    r_idx_lo[sas_pkg::CAP_BITS-1:sas_pkg::PW_BITS];
                                mem_req.pres_wdata = w_pres_rdata & ~ex_bit;
                            end
                        end
                        sas_pkg::FUNC_SETLEN: begin
                            if (!r_nl_ok) begin
                                n_status = sas_pkg::ST_CAPACITY;
                            end else begin
                                n_len = r_nl;
                                if (ex_trunc) begin
                                    mem_req.pres_we    = 1'b1;
                                    mem_req.pres_waddr = trunc_row;
                                    mem_req.pres_wdata = w_pres_rdata &
                                        sas_pkg::low_mask(r_nl[sas_pkg::PW_BITS-1:0]);
                                    n_row     = trunc_row + sas_pkg::ROW_AW'(1);
                                    n_row_end = last_row;
                                end
                            end
                        end
                        default: n_status = sas_pkg::ST_DONE;
                    endcase
                    n_out_len = n_len;
                end
            end
            sas_pkg::S_CLEAR: begin
                mem_req.pres_we    = 1'b1;
                mem_req.pres_waddr = r_row;
                mem_req.pres_wdata = '0;
                n_row = r_row + sas_pkg::ROW_AW'(1);
            end
            default: mem_req = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= sas_pkg::S_IDLE;
            r_len       <= '0;
            r_dense     <= 1'b1;
            r_row       <= '0;
            r_row_end   <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_len       <= n_len;
            r_dense     <= n_dense;
            r_row       <= n_row;
            r_row_end   <= n_row_end;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func    <= n_func;
        r_idx_ok  <= n_idx_ok;
        r_idx_lo  <= n_idx_lo;
        r_wval    <= n_wval;
        r_nl_ok   <= n_nl_ok;
        r_nl      <= n_nl;
        r_status  <= n_status;
        r_rdata   <= n_rdata;
        r_out_len <= n_out_len;
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_status;
    assign o_rsp.read_value = r_rdata;
    assign o_rsp.cur_length = r_out_len;

    // once sparse, never dense again
    a_stay_sparse: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_dense |=> !r_dense)
        else $error("store returned to dense mode");

    a_len_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_len <= sas_pkg::LEN_W'(sas_pkg::CAPACITY))
        else $error("length beyond capacity");

    // presence writes never collide with a read pass
    a_pres_wr_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mem_req.pres_we |-> (r_state == sas_pkg::S_SWEEP || r_state == sas_pkg::S_EXEC ||
                             r_state == sas_pkg::S_CLEAR))
        else $error("presence write outside sweep, execute or clear");

    a_exec_leaves: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == sas_pkg::S_EXEC && out_free) |=> r_state != sas_pkg::S_EXEC)
        else $error("execute step repeated");

    a_clear_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == sas_pkg::S_CLEAR |-> r_row <= r_row_end)
        else $error("clear pass ran past the old length");

endmodule
